### hdl/sfq_pkg.sv
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types and codes for the searchable fifo queue.
// ----------------------------------------------------------------------------
package sfq_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_REMOVE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_COMPARE,
    CELL_WAVE,
    CELL_REMOVE
  } cell_cmd_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WAVE,
    SEQ_FINISH
  } seq_state_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [DataW-1:0]   key;
  } cell_ctrl_t;

endpackage

### hdl/searchable_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// searchable_fifo_queue_top
// FIFO queue of signed 32-bit values with enqueue, dequeue, search and
// remove-first-match, built as a row of cells.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                         | tuser
//  s_axis   | in        | [31:0] value                  | [1:0] op
//  m_axis   | out       | [31:0] data, [36:32] occupancy| [1:0] status, [2] found
//
//  enqueue and dequeue register their result at acceptance. search and remove
//  run a compare step, then the match flag ripples along the cell row, then a
//  finish step registers the result. one transaction is in work at a time;
//  the next is taken once the output register is free or being drained. reset
//  clears the count, not the entries.
// ----------------------------------------------------------------------------
module searchable_fifo_queue_top
  import sfq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] data, [36:32] occupancy, rest zero
  output logic [2:0]  m_axis_tuser    // [1:0] status, [2] found
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = (DEPTH > 2) ? $clog2(DEPTH - 1) : 1;
  localparam logic [WW-1:0] WaveLast = WW'(DEPTH - 2);

  seq_state_e       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [WW-1:0]    wave_q, wave_d;
  op_e              op_q;
  logic             out_valid_q;
  logic [39:0]      out_data_q;
  logic [2:0]       out_user_q;

  cell_ctrl_t       ctrl;
  logic [DataW-1:0] head;
  logic             last_pre;
  logic             accept;
  logic             out_free;
  op_e              in_op;

  logic             res_load;
  status_e          res_status;
  logic             res_found;
  logic [DataW-1:0] res_data;

  assign in_op         = op_e'(s_axis_tuser);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == SEQ_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sfq_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .count_i    (count_q),
    .head_o     (head),
    .last_pre_o (last_pre)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (accept && (in_op == OP_SEARCH || in_op == OP_REMOVE)) begin
          state_d = SEQ_WAVE;
        end
      end
      SEQ_WAVE: begin
        if (wave_q == WaveLast) begin
          state_d = SEQ_FINISH;
        end
      end
      SEQ_FINISH: state_d = SEQ_IDLE;
      default:    state_d = SEQ_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl.cmd   = CELL_HOLD;
    ctrl.key   = s_axis_tdata;
    count_d    = count_q;
    wave_d     = wave_q;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_found  = 1'b0;
    res_data   = '0;
    unique case (state_q)
      SEQ_IDLE: begin
        wave_d = '0;
        if (accept) begin
          unique case (in_op)
            OP_ENQUEUE: begin
              res_load = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                ctrl.cmd = CELL_LOAD;
                count_d  = count_q + 1'b1;
              end
            end
            OP_DEQUEUE: begin
              res_load = 1'b1;
              if (count_q == '0) begin
                res_status = ST_EMPTY;
              end else begin
                ctrl.cmd = CELL_SHIFT;
                res_data = head;
                count_d  = count_q - 1'b1;
              end
            end
            default: ctrl.cmd = CELL_COMPARE;
          endcase
        end
      end
      SEQ_WAVE: begin
        ctrl.cmd = CELL_WAVE;
        wave_d   = wave_q + 1'b1;
      end
      SEQ_FINISH: begin
        res_load = 1'b1;
        if (last_pre) begin
          res_found = 1'b1;
          if (op_q == OP_REMOVE) begin
            ctrl.cmd = CELL_REMOVE;
            count_d  = count_q - 1'b1;
          end
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      count_q     <= '0;
      wave_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wave_q  <= wave_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_op;
    end
    if (res_load) begin
      out_data_q <= {3'b000, 5'(count_d), res_data};
      out_user_q <= {res_found, res_status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### hdl/sfq_cell.sv
// ----------------------------------------------------------------------------
// sfq_cell
// One queue slot: holds an entry and a match flag that ripples toward the tail.
// ----------------------------------------------------------------------------
module sfq_cell
  import sfq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CW-1:0]     count_i,
  input  logic [DataW-1:0]  next_entry_i,
  input  logic              prev_pre_i,
  output logic [DataW-1:0]  entry_o,
  output logic              pre_o
);

  logic [DataW-1:0] entry_q, entry_d;
  logic             pre_q, pre_d;
  logic             occupied;

  assign occupied = CW'(IDX) < count_i;

  always_comb begin
    entry_d = entry_q;
    pre_d   = pre_q;
    unique case (ctrl_i.cmd)
      CELL_LOAD: begin
        if (CW'(IDX) == count_i) begin
          entry_d = ctrl_i.key;
        end
      end
      CELL_SHIFT:   entry_d = next_entry_i;
      CELL_COMPARE: pre_d   = occupied && (entry_q == ctrl_i.key);
      // prefix or of the hits, one cell further each cycle
      CELL_WAVE:    pre_d   = pre_q | prev_pre_i;
      CELL_REMOVE: begin
        if (pre_q) begin
          entry_d = next_entry_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    pre_q   <= pre_d;
  end

  assign entry_o = entry_q;
  assign pre_o   = pre_q;

endmodule

### hdl/sfq_chain.sv
// ----------------------------------------------------------------------------
// sfq_chain
// Row of queue cells, head at cell 0, each linked to its neighbors.
// ----------------------------------------------------------------------------
module sfq_chain
  import sfq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CW-1:0]     count_i,
  output logic [DataW-1:0]  head_o,
  output logic              last_pre_o
);

  logic [DataW-1:0] entry [DEPTH];
  logic             pre   [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] nxt;
    logic             prv;

    if (g == DEPTH - 1) begin : g_tail
      assign nxt = entry[g];
    end else begin : g_mid
      assign nxt = entry[g+1];
    end

    if (g == 0) begin : g_head
      assign prv = 1'b0;
    end else begin : g_rest
      assign prv = pre[g-1];
    end

    sfq_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .count_i      (count_i),
      .next_entry_i (nxt),
      .prev_pre_i   (prv),
      .entry_o      (entry[g]),
      .pre_o        (pre[g])
    );
  end

  assign head_o     = entry[0];
  assign last_pre_o = pre[DEPTH-1];

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the searchable fifo queue: a shadow queue predicts
// status, found flag, dequeued data and occupancy for every accepted
// transaction, and each reply is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import sfq_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam int unsigned NumRandom = 1500;
  localparam int unsigned QuietTail = 200;
  localparam int unsigned LongStall = 120;

  typedef struct {
    status_e     status;
    logic        found;
    logic [31:0] data;
    logic [4:0]  occupancy;
  } reply_t;

  // shadow of the queue contents plus the replies it predicts
  class sfq_shadow #(int unsigned CAP = 16);
    logic [31:0] held[$];
    reply_t      pending[$];
    int unsigned errors;
    int unsigned n_op[4];
    int unsigned n_full, n_empty, n_hit, n_miss, max_fill;

    function int locate(logic [31:0] key);
      foreach (held[i]) begin
        if (held[i] == key) return i;
      end
      return -1;
    endfunction

    function void apply_op(op_e op, logic [31:0] key);
      reply_t r;
      int pos;
      r.status    = ST_OK;
      r.found     = 1'b0;
      r.data      = '0;
      r.occupancy = '0;
      n_op[op]++;
      case (op)
        OP_ENQUEUE: begin
          if (held.size() >= CAP) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            held.push_back(key);
          end
        end
        OP_DEQUEUE: begin
          if (held.size() == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            r.data = held.pop_front();
          end
        end
        default: begin
          pos = locate(key);
          if (pos < 0) begin
            r.status = ST_NOT_FOUND;
            n_miss++;
          end else begin
            r.found = 1'b1;
            n_hit++;
            if (op == OP_REMOVE) held.delete(pos);
          end
        end
      endcase
      r.occupancy = 5'(held.size());
      if (held.size() > max_fill) max_fill = held.size();
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_reply(logic [2:0] user, logic [39:0] tdata);
      reply_t e;
      if (pending.size() == 0) begin
        report($sformatf("reply with nothing pending, tuser=%h tdata=%h", user, tdata));
        return;
      end
      e = pending.pop_front();
      if (user[1:0] !== e.status)
        report($sformatf("status %0d, expected %0d", user[1:0], e.status));
      if (user[2] !== e.found)
        report($sformatf("found %b, expected %b", user[2], e.found));
      if (tdata[31:0] !== e.data)
        report($sformatf("data %h, expected %h", tdata[31:0], e.data));
      if (tdata[36:32] !== e.occupancy)
        report($sformatf("occupancy %0d, expected %0d", tdata[36:32], e.occupancy));
      if (tdata[39:37] !== 3'b000)
        report($sformatf("tdata padding %b not zero", tdata[39:37]));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value
  logic [1:0]  s_axis_tuser;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] data, [36:32] occupancy, rest zero
  logic [2:0]  m_axis_tuser;   // [1:0] status, [2] found

  sfq_shadow #(Depth) sb;
  int unsigned n_sent;
  bit          quiet;
  logic [31:0] key_pool[6];

  searchable_fifo_queue_top #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d replies outstanding", sb.pending.size());
    $display("TB_ERROR");
    $finish;
  end

  // offer one transaction and hold it until accepted, then maybe idle
  task automatic send_item(input op_e op, input logic [31:0] value);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_op(op, value);
    n_sent++;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic op_e pick_op(int unsigned mood);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mood)
      0: begin  // filling
        if (roll < 55) return OP_ENQUEUE;
        if (roll < 70) return OP_DEQUEUE;
        if (roll < 85) return OP_SEARCH;
        return OP_REMOVE;
      end
      1: begin  // draining
        if (roll < 15) return OP_ENQUEUE;
        if (roll < 60) return OP_DEQUEUE;
        if (roll < 80) return OP_SEARCH;
        return OP_REMOVE;
      end
      default: return op_e'(roll[1:0]);
    endcase
  endfunction

  // keys drawn from held entries, a small pool, or anywhere in the range
  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45 && sb.held.size() != 0)
      return sb.held[$urandom_range(0, sb.held.size() - 1)];
    if (roll < 80) return key_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // receiver: random holds, one long hold-off, steady in the last part
  initial begin
    bit long_done;
    long_done = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_done && n_sent >= 400) begin
        m_axis_tready <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
        long_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tuser, m_axis_tdata);
  end

  initial begin
    int unsigned mood, left;
    sb = new();
    n_sent = 0;
    quiet  = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_ENQUEUE;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0000_0000;
    key_pool[4] = $urandom;
    key_pool[5] = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue corner cases
    send_item(OP_DEQUEUE, 32'h0000_0000);
    send_item(OP_SEARCH,  32'h0000_0000);
    send_item(OP_REMOVE,  32'hffff_ffff);
    // extremes of the value range
    send_item(OP_ENQUEUE, 32'h7fff_ffff);
    send_item(OP_ENQUEUE, 32'h8000_0000);
    send_item(OP_ENQUEUE, 32'hffff_ffff);
    send_item(OP_ENQUEUE, 32'h0000_0000);
    send_item(OP_ENQUEUE, 32'h8000_0000);
    send_item(OP_SEARCH,  32'h8000_0000);
    send_item(OP_SEARCH,  32'h0000_0001);
    // removal of the first of two duplicates, at tail and head, a miss, then dequeues
    send_item(OP_REMOVE,  32'h8000_0000);
    send_item(OP_REMOVE,  32'h8000_0000);
    send_item(OP_REMOVE,  32'h7fff_ffff);
    send_item(OP_REMOVE,  32'h0000_0001);
    send_item(OP_DEQUEUE, 32'hffff_ffff);
    send_item(OP_DEQUEUE, 32'h0000_0000);
    send_item(OP_DEQUEUE, 32'h0000_0000);

    mood = 2;
    left = 0;
    for (int unsigned i = 0; i < NumRandom; i++) begin
      if (left == 0) begin
        mood = $urandom_range(0, 2);
        left = $urandom_range(20, 80);
      end
      left--;
      if (i == NumRandom - QuietTail) quiet = 1'b1;
      send_item(pick_op(mood), pick_value());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3 * Depth) @(posedge clk_i);

    $display("ran %0d transactions: %0d enqueue, %0d dequeue, %0d search, %0d remove",
             n_sent, sb.n_op[OP_ENQUEUE], sb.n_op[OP_DEQUEUE], sb.n_op[OP_SEARCH],
             sb.n_op[OP_REMOVE]);
    $display("full refusals %0d, empty dequeues %0d, key hits %0d, misses %0d, peak fill %0d",
             sb.n_full, sb.n_empty, sb.n_hit, sb.n_miss, sb.max_fill);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
